[sv/tab_pkg.sv]
// ----------------------------------------------------------------------------
// tab_pkg: shared constants for the transformed box bounds block
// Number format widths for coordinates, matrix coefficients and fractions.
// ----------------------------------------------------------------------------
package tab_pkg;

  // Coordinates are signed Q(COORD_BITS-16).16.
  localparam int COORD_BITS = 32;
  // Coefficients are signed Q(COEF_BITS-16).16.
  localparam int COEF_BITS  = 20;
  // Fraction bits shared by both formats.
  localparam int FRAC_BITS  = 16;

endpackage

[sv/transformed_aabb_bounds.sv]
// ----------------------------------------------------------------------------
// transformed_aabb_bounds: bounding box of an affinely transformed box
// Arvo's method in fixed point: nine multiply lanes, then three saturating
// accumulation stages, one per matrix row.
// ----------------------------------------------------------------------------
// The block takes one box word in every cycle: busy_o never rises, so start_i
// may be held high continuously. Each word's result is flagged by a one-cycle
// done_o pulse, and results come out in the order the words were started. The
// path holds one input register, one register after the eighteen coefficient
// multipliers and one register for each of the three matrix rows, since each
// row's sum is clamped before the next is added.
// Results must be captured in the cycle done_o is high.
module transformed_aabb_bounds #(
  parameter int CoordBits = tab_pkg::COORD_BITS,
  parameter int CoefBits  = tab_pkg::COEF_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [3*CoefBits-1:0]       row_x_coeffs_i,
  input  logic [3*CoefBits-1:0]       row_y_coeffs_i,
  input  logic [3*CoefBits-1:0]       row_z_coeffs_i,
  input  logic signed [CoordBits-1:0] shift_x_i,
  input  logic signed [CoordBits-1:0] shift_y_i,
  input  logic signed [CoordBits-1:0] shift_z_i,
  input  logic signed [CoordBits-1:0] in_min_x_i,
  input  logic signed [CoordBits-1:0] in_min_y_i,
  input  logic signed [CoordBits-1:0] in_min_z_i,
  input  logic signed [CoordBits-1:0] in_max_x_i,
  input  logic signed [CoordBits-1:0] in_max_y_i,
  input  logic signed [CoordBits-1:0] in_max_z_i,
  output logic                        done_o,
  output logic signed [CoordBits-1:0] out_min_x_o,
  output logic signed [CoordBits-1:0] out_min_y_o,
  output logic signed [CoordBits-1:0] out_min_z_o,
  output logic signed [CoordBits-1:0] out_max_x_o,
  output logic signed [CoordBits-1:0] out_max_y_o,
  output logic signed [CoordBits-1:0] out_max_z_o
);
  import tab_pkg::*;

  localparam int FullBits = CoefBits + CoordBits;
  localparam int ProdBits = FullBits - FRAC_BITS;

  // Input register.
  logic                        v0_q;
  logic signed [CoefBits-1:0]  coef_q [3][3];
  logic signed [CoordBits-1:0] smin_q [3];
  logic signed [CoordBits-1:0] smax_q [3];
  logic signed [CoordBits-1:0] shift0_q [3];
  logic [3*CoefBits-1:0]       rows_in [3];

  // Product stage.
  logic                        v1_q;
  logic signed [FullBits-1:0]  full_min [3][3];
  logic signed [FullBits-1:0]  full_max [3][3];
  logic signed [ProdBits-1:0]  pmin_d [3][3];
  logic signed [ProdBits-1:0]  pmax_d [3][3];
  logic signed [ProdBits-1:0]  pmin_q [3][3];
  logic signed [ProdBits-1:0]  pmax_q [3][3];
  logic signed [CoordBits-1:0] shift1_q [3];

  // Later rows' products wait beside the accumulation stages.
  logic signed [ProdBits-1:0]  p2min_row1_q [3];
  logic signed [ProdBits-1:0]  p2max_row1_q [3];
  logic signed [ProdBits-1:0]  p2min_row2_q [3];
  logic signed [ProdBits-1:0]  p2max_row2_q [3];
  logic signed [ProdBits-1:0]  p3min_row2_q [3];
  logic signed [ProdBits-1:0]  p3max_row2_q [3];

  logic                        v2, v3, v4;
  logic signed [CoordBits-1:0] acc2_min [3];
  logic signed [CoordBits-1:0] acc2_max [3];
  logic signed [CoordBits-1:0] acc3_min [3];
  logic signed [CoordBits-1:0] acc3_max [3];
  logic signed [CoordBits-1:0] acc4_min [3];
  logic signed [CoordBits-1:0] acc4_max [3];

  assign busy_o = 1'b0;

  assign rows_in[0] = row_x_coeffs_i;
  assign rows_in[1] = row_y_coeffs_i;
  assign rows_in[2] = row_z_coeffs_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= start_i && !busy_o;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        coef_q[r][k] <= rows_in[r][k*CoefBits +: CoefBits];
      end
    end
    smin_q[0]   <= in_min_x_i;
    smin_q[1]   <= in_min_y_i;
    smin_q[2]   <= in_min_z_i;
    smax_q[0]   <= in_max_x_i;
    smax_q[1]   <= in_max_y_i;
    smax_q[2]   <= in_max_z_i;
    shift0_q[0] <= shift_x_i;
    shift0_q[1] <= shift_y_i;
    shift0_q[2] <= shift_z_i;
  end

  // A positive coefficient keeps the corners; zero or negative swaps them.
  // Dropping the low fraction bits of the exact product floors it.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        if (!coef_q[r][k][CoefBits-1] && (|coef_q[r][k])) begin
          full_min[r][k] = coef_q[r][k] * smin_q[r];
          full_max[r][k] = coef_q[r][k] * smax_q[r];
        end else begin
          full_min[r][k] = coef_q[r][k] * smax_q[r];
          full_max[r][k] = coef_q[r][k] * smin_q[r];
        end
        pmin_d[r][k] = full_min[r][k][FullBits-1:FRAC_BITS];
        pmax_d[r][k] = full_max[r][k][FullBits-1:FRAC_BITS];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pmin_q   <= pmin_d;
    pmax_q   <= pmax_d;
    shift1_q <= shift0_q;
    p2min_row1_q <= pmin_q[1];
    p2max_row1_q <= pmax_q[1];
    p2min_row2_q <= pmin_q[2];
    p2max_row2_q <= pmax_q[2];
    p3min_row2_q <= p2min_row2_q;
    p3max_row2_q <= p2max_row2_q;
  end

  // Both corners start from the translation.
  tab_acc_stage #(
    .CoordBits (CoordBits),
    .ProdBits  (ProdBits)
  ) u_acc_row0 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v1_q),
    .acc_min_i  (shift1_q),
    .acc_max_i  (shift1_q),
    .term_min_i (pmin_q[0]),
    .term_max_i (pmax_q[0]),
    .valid_o    (v2),
    .acc_min_o  (acc2_min),
    .acc_max_o  (acc2_max)
  );

  tab_acc_stage #(
    .CoordBits (CoordBits),
    .ProdBits  (ProdBits)
  ) u_acc_row1 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v2),
    .acc_min_i  (acc2_min),
    .acc_max_i  (acc2_max),
    .term_min_i (p2min_row1_q),
    .term_max_i (p2max_row1_q),
    .valid_o    (v3),
    .acc_min_o  (acc3_min),
    .acc_max_o  (acc3_max)
  );

  tab_acc_stage #(
    .CoordBits (CoordBits),
    .ProdBits  (ProdBits)
  ) u_acc_row2 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v3),
    .acc_min_i  (acc3_min),
    .acc_max_i  (acc3_max),
    .term_min_i (p3min_row2_q),
    .term_max_i (p3max_row2_q),
    .valid_o    (v4),
    .acc_min_o  (acc4_min),
    .acc_max_o  (acc4_max)
  );

  assign done_o      = v4;
  assign out_min_x_o = acc4_min[0];
  assign out_min_y_o = acc4_min[1];
  assign out_min_z_o = acc4_min[2];
  assign out_max_x_o = acc4_max[0];
  assign out_max_y_o = acc4_max[1];
  assign out_max_z_o = acc4_max[2];

  // Every started word is later flagged by done_o.
  a_start_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##5 done_o)
    else $error("started word did not complete after five cycles");

  // No result appears without a matching started word.
  a_done_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 5))
    else $error("result strobe without a matching start");

  // An ordered source box maps to an ordered result box.
  a_order_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && (in_min_x_i <= in_max_x_i) && (in_min_y_i <= in_max_y_i)
     && (in_min_z_i <= in_max_z_i))
    |-> ##5 ((out_min_x_o <= out_max_x_o) && (out_min_y_o <= out_max_y_o)
             && (out_min_z_o <= out_max_z_o)))
    else $error("ordered source box produced an inverted result");

endmodule

[sv/tab_acc_stage.sv]
// ----------------------------------------------------------------------------
// tab_acc_stage: one saturating accumulation stage
// Adds one row of product terms to the running min and max corners of all
// three axes, clamps each sum to the coordinate range and registers it.
// ----------------------------------------------------------------------------
module tab_acc_stage #(
  parameter int CoordBits = tab_pkg::COORD_BITS,
  parameter int ProdBits  = tab_pkg::COORD_BITS + tab_pkg::COEF_BITS - tab_pkg::FRAC_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic signed [CoordBits-1:0] acc_min_i  [3],
  input  logic signed [CoordBits-1:0] acc_max_i  [3],
  input  logic signed [ProdBits-1:0]  term_min_i [3],
  input  logic signed [ProdBits-1:0]  term_max_i [3],
  output logic                        valid_o,
  output logic signed [CoordBits-1:0] acc_min_o  [3],
  output logic signed [CoordBits-1:0] acc_max_o  [3]
);
  import tab_pkg::*;

  // One bit of headroom over the wider operand keeps the sum exact.
  localparam int SumBits = ((ProdBits > CoordBits) ? ProdBits : CoordBits) + 1;

  function automatic logic signed [CoordBits-1:0] sat_coord(
    input logic signed [SumBits-1:0] s
  );
    logic [SumBits-CoordBits:0] hi_bits;
    hi_bits = s[SumBits-1:CoordBits-1];
    // The sum fits when all bits above the coordinate sign agree with it.
    if (!hi_bits[SumBits-CoordBits] && (|hi_bits)) begin
      return {1'b0, {(CoordBits-1){1'b1}}};
    end else if (hi_bits[SumBits-CoordBits] && !(&hi_bits)) begin
      return {1'b1, {(CoordBits-1){1'b0}}};
    end else begin
      return s[CoordBits-1:0];
    end
  endfunction

  logic                        valid_q;
  logic signed [CoordBits-1:0] min_d [3];
  logic signed [CoordBits-1:0] max_d [3];
  logic signed [CoordBits-1:0] min_q [3];
  logic signed [CoordBits-1:0] max_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      min_d[k] = sat_coord(SumBits'(acc_min_i[k]) + SumBits'(term_min_i[k]));
      max_d[k] = sat_coord(SumBits'(acc_max_i[k]) + SumBits'(term_max_i[k]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      min_q[k] <= min_d[k];
      max_q[k] <= max_d[k];
    end
  end

  assign valid_o   = valid_q;
  assign acc_min_o = min_q;
  assign acc_max_o = max_q;

endmodule
